// ===== hdl/zip_stored_entry_extractor_top_assert.svh =====
// Assertion macros for the stored entry extractor.
// Each macro expands to a concurrent assertion in simulation and to nothing
// when the code is read by synthesis.
`ifndef ZIP_STORED_ENTRY_EXTRACTOR_TOP_ASSERT_SVH
`define ZIP_STORED_ENTRY_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define ZSEE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("zsee assertion failed");

`define ZSEE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("zsee assertion failed");

`define ZSEE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("zsee assertion failed");

`else

`define ZSEE_ASSERT(lbl, clk, rst, prop)
`define ZSEE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ZSEE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/zsee_pkg.sv =====
// ----------------------------------------------------------------------------
// zsee_pkg
// Types and constants shared by the stored entry extractor modules.
// ----------------------------------------------------------------------------
package zsee_pkg;

   localparam logic [31:0] LOCAL_SIG      = 32'h04034b50;
   localparam logic [7:0]  DESC_FLAG_MASK = 8'h08;
   localparam int unsigned HDR_LEN        = 30;

   // Header byte offsets of the captured fields.
   localparam logic [4:0] POS_SIG_LAST  = 5'd3;
   localparam logic [4:0] POS_FLAGS     = 5'd6;
   localparam logic [4:0] POS_METHOD_LO = 5'd8;
   localparam logic [4:0] POS_METHOD_HI = 5'd9;
   localparam logic [4:0] POS_PACKED    = 5'd18;
   localparam logic [4:0] POS_UNPACKED  = 5'd22;
   localparam logic [4:0] POS_NAME_LO   = 5'd26;
   localparam logic [4:0] POS_NAME_HI   = 5'd27;
   localparam logic [4:0] POS_EXTRA_LO  = 5'd28;
   localparam logic [4:0] POS_EXTRA_HI  = 5'd29;
   localparam logic [4:0] POS_HDR_LAST  = 5'(HDR_LEN - 1);

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER = 3'd1;
   localparam logic [2:0] ST_DESCRIPTOR = 3'd2;
   localparam logic [2:0] ST_TRUNCATED  = 3'd3;
   localparam logic [2:0] ST_NO_STORED  = 3'd4;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAMEX,
      PH_EMIT,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] out_byte;
      logic       entry_last;
      logic [2:0] status;
   } rsp_item_type;

   // Up to two results per input transaction; item1 is used only with item0.
   typedef struct packed {
      logic         wr0;
      logic         wr1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   function automatic rsp_item_type status_item(input logic [2:0] st);
      rsp_item_type it;
      it.result_kind = KIND_STATUS;
      it.out_byte    = 8'd0;
      it.entry_last  = 1'b0;
      it.status      = st;
      return it;
   endfunction

   function automatic rsp_item_type data_item(input logic [7:0] b, input logic lst);
      rsp_item_type it;
      it.result_kind = KIND_DATA;
      it.out_byte    = b;
      it.entry_last  = lst;
      it.status      = ST_OK;
      return it;
   endfunction

endpackage

// ===== hdl/zsee_parser.sv =====
// ----------------------------------------------------------------------------
// zsee_parser
// Local header parser and entry sequencer: one archive byte per accepted
// transaction, producing zero, one or two result items for the output queue.
// ----------------------------------------------------------------------------
module zsee_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            archive_byte,
   input  logic                  archive_last,
   output zsee_pkg::rsp_push_type push
);

   zsee_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  header_pos_ff, header_pos_in;
   logic [23:0] sig_ff, sig_in;
   logic        desc_ff, desc_in;
   logic [15:0] method_ff, method_in;
   logic [31:0] packed_ff, packed_in;
   logic [31:0] unpacked_ff, unpacked_in;
   logic [15:0] name_ff, name_in;
   logic [15:0] extra_ff, extra_in;
   logic [31:0] bytes_left_ff, bytes_left_in;

   logic        sig_bad;
   logic        hdr_end;
   logic [16:0] namex_len;
   logic        namex_zero;
   logic [31:0] left_dec;
   logic        left_zero;
   logic        store_ok;
   logic        packed_zero;

   assign sig_bad   = (header_pos_ff == zsee_pkg::POS_SIG_LAST) &&
                      ({archive_byte, sig_ff} != zsee_pkg::LOCAL_SIG);
   assign hdr_end   = (header_pos_ff == zsee_pkg::POS_HDR_LAST);
   assign left_dec  = bytes_left_ff - 32'd1;
   assign left_zero = (left_dec == 32'd0);
   // The sizes and method are complete by the time they are looked at.
   assign packed_zero = (packed_ff == 32'd0);
   assign store_ok    = (method_ff == 16'd0) && (packed_ff == unpacked_ff) &&
                        (unpacked_ff != 32'd0);

   // Field capture. Every byte lane is written once per header, so the
   // fields need no clearing at the start of a header.
   always_comb begin
      sig_in      = sig_ff;
      desc_in     = desc_ff;
      method_in   = method_ff;
      packed_in   = packed_ff;
      unpacked_in = unpacked_ff;
      name_in     = name_ff;
      extra_in    = extra_ff;
      if (accept && (phase_ff == zsee_pkg::PH_HEADER)) begin
         if (header_pos_ff < zsee_pkg::POS_SIG_LAST) begin
            sig_in = {archive_byte, sig_ff[23:8]};
         end
         if (header_pos_ff == zsee_pkg::POS_FLAGS) begin
            desc_in = |(archive_byte & zsee_pkg::DESC_FLAG_MASK);
         end
         if (header_pos_ff == zsee_pkg::POS_METHOD_LO) begin
            method_in[7:0] = archive_byte;
         end
         if (header_pos_ff == zsee_pkg::POS_METHOD_HI) begin
            method_in[15:8] = archive_byte;
         end
         if ((header_pos_ff >= zsee_pkg::POS_PACKED) &&
             (header_pos_ff < zsee_pkg::POS_UNPACKED)) begin
            packed_in[8 * 2'(header_pos_ff - zsee_pkg::POS_PACKED) +: 8] = archive_byte;
         end
         if ((header_pos_ff >= zsee_pkg::POS_UNPACKED) &&
             (header_pos_ff < zsee_pkg::POS_NAME_LO)) begin
            unpacked_in[8 * 2'(header_pos_ff - zsee_pkg::POS_UNPACKED) +: 8] =
               archive_byte;
         end
         if (header_pos_ff == zsee_pkg::POS_NAME_LO) begin
            name_in[7:0] = archive_byte;
         end
         if (header_pos_ff == zsee_pkg::POS_NAME_HI) begin
            name_in[15:8] = archive_byte;
         end
         if (header_pos_ff == zsee_pkg::POS_EXTRA_LO) begin
            extra_in[7:0] = archive_byte;
         end
         if (header_pos_ff == zsee_pkg::POS_EXTRA_HI) begin
            extra_in[15:8] = archive_byte;
         end
      end
   end

   assign namex_len  = {1'b0, name_in} + {1'b0, extra_in};
   assign namex_zero = (namex_len == 17'd0);

   // Next state.
   always_comb begin
      phase_in      = phase_ff;
      header_pos_in = header_pos_ff;
      bytes_left_in = bytes_left_ff;
      if (accept) begin
         unique case (phase_ff)
            zsee_pkg::PH_HEADER: begin
               if (sig_bad) begin
                  phase_in = zsee_pkg::PH_DONE;
               end else if (!hdr_end) begin
                  header_pos_in = header_pos_ff + 5'd1;
               end else begin
                  header_pos_in = 5'd0;
                  bytes_left_in = {15'd0, namex_len};
                  if (!namex_zero) begin
                     phase_in = zsee_pkg::PH_NAMEX;
                  end else if (desc_in) begin
                     phase_in = zsee_pkg::PH_DONE;
                  end else if (store_ok) begin
                     phase_in      = zsee_pkg::PH_EMIT;
                     bytes_left_in = packed_ff;
                  end else if (!packed_zero) begin
                     phase_in      = zsee_pkg::PH_SKIP;
                     bytes_left_in = packed_ff;
                  end
               end
            end
            zsee_pkg::PH_NAMEX: begin
               bytes_left_in = left_dec;
               if (left_zero) begin
                  if (desc_ff) begin
                     phase_in = zsee_pkg::PH_DONE;
                  end else if (store_ok) begin
                     phase_in      = zsee_pkg::PH_EMIT;
                     bytes_left_in = packed_ff;
                  end else if (!packed_zero) begin
                     phase_in      = zsee_pkg::PH_SKIP;
                     bytes_left_in = packed_ff;
                  end else begin
                     phase_in      = zsee_pkg::PH_HEADER;
                     header_pos_in = 5'd0;
                  end
               end
            end
            zsee_pkg::PH_EMIT: begin
               bytes_left_in = left_dec;
               if (left_zero) begin
                  phase_in = zsee_pkg::PH_DONE;
               end
            end
            zsee_pkg::PH_SKIP: begin
               bytes_left_in = left_dec;
               if (left_zero) begin
                  phase_in      = zsee_pkg::PH_HEADER;
                  header_pos_in = 5'd0;
               end
            end
            zsee_pkg::PH_DONE: begin
            end
            default: begin
               phase_in = zsee_pkg::PH_HEADER;
            end
         endcase
         // The final byte of an archive always re-arms the parser.
         if (archive_last) begin
            phase_in      = zsee_pkg::PH_HEADER;
            header_pos_in = 5'd0;
         end
      end
   end

   // Result items.
   always_comb begin
      push.wr0   = 1'b0;
      push.wr1   = 1'b0;
      push.item0 = zsee_pkg::status_item(zsee_pkg::ST_NO_STORED);
      push.item1 = zsee_pkg::status_item(zsee_pkg::ST_TRUNCATED);
      if (accept) begin
         unique case (phase_ff)
            zsee_pkg::PH_HEADER: begin
               if (sig_bad) begin
                  push.wr0 = 1'b1;
               end else if (!hdr_end) begin
                  push.wr0 = archive_last;
               end else if (!namex_zero) begin
                  push.wr0   = archive_last;
                  push.item0 = zsee_pkg::status_item(zsee_pkg::ST_BAD_HEADER);
               end else if (desc_in) begin
                  push.wr0   = 1'b1;
                  push.item0 = zsee_pkg::status_item(zsee_pkg::ST_DESCRIPTOR);
               end else if (archive_last) begin
                  push.wr0 = 1'b1;
                  if (!packed_zero) begin
                     push.item0 = zsee_pkg::status_item(zsee_pkg::ST_TRUNCATED);
                  end
               end
            end
            zsee_pkg::PH_NAMEX: begin
               if (!left_zero) begin
                  push.wr0   = archive_last;
                  push.item0 = zsee_pkg::status_item(zsee_pkg::ST_BAD_HEADER);
               end else if (desc_ff) begin
                  push.wr0   = 1'b1;
                  push.item0 = zsee_pkg::status_item(zsee_pkg::ST_DESCRIPTOR);
               end else if (archive_last) begin
                  push.wr0 = 1'b1;
                  if (!packed_zero) begin
                     push.item0 = zsee_pkg::status_item(zsee_pkg::ST_TRUNCATED);
                  end
               end
            end
            zsee_pkg::PH_EMIT: begin
               push.wr0   = 1'b1;
               push.item0 = zsee_pkg::data_item(archive_byte, left_zero);
               // An archive that ends inside the entry adds a status item.
               push.wr1   = archive_last && !left_zero;
            end
            zsee_pkg::PH_SKIP: begin
               push.wr0 = archive_last;
               if (!left_zero) begin
                  push.item0 = zsee_pkg::status_item(zsee_pkg::ST_TRUNCATED);
               end
            end
            zsee_pkg::PH_DONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= zsee_pkg::PH_HEADER;
         header_pos_ff <= 5'd0;
         bytes_left_ff <= 32'd0;
      end else begin
         phase_ff      <= phase_in;
         header_pos_ff <= header_pos_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      sig_ff      <= sig_in;
      desc_ff     <= desc_in;
      method_ff   <= method_in;
      packed_ff   <= packed_in;
      unpacked_ff <= unpacked_in;
      name_ff     <= name_in;
      extra_ff    <= extra_in;
   end

endmodule

// ===== hdl/zsee_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// zsee_rsp_fifo
// Result queue taking up to two items per cycle and giving one per
// transaction on the result channel.
// ----------------------------------------------------------------------------
`include "zip_stored_entry_extractor_top_assert.svh"

module zsee_rsp_fifo #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  zsee_pkg::rsp_push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output zsee_pkg::rsp_item_type out_item
);

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   zsee_pkg::rsp_item_type mem [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RSP_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop         = out_valid && out_ready;
   assign out_valid   = (count_ff != '0);
   assign out_item    = mem[rd_ptr_ff];
   // Two free places are kept so that any transaction's results fit.
   assign room        = (count_ff <= CNT_W'(RSP_DEPTH - 2));
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.wr1) begin
         wr_ptr_in = ptr_inc(wr_ptr_next);
      end else if (push.wr0) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.wr0) + CNT_W'(push.wr1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.wr0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.wr1) begin
         mem[wr_ptr_next] <= push.item1;
      end
   end

   `ZSEE_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(RSP_DEPTH))
   `ZSEE_ASSERT_IMPL(a_pair_order, clock, reset, push.wr1, push.wr0)
   `ZSEE_ASSERT_IMPL(a_push_room, clock, reset, push.wr0, room)
   `ZSEE_ASSERT_NEXT(a_hold_head, clock, reset, out_valid && !out_ready, $stable(rd_ptr_ff))

endmodule

// ===== hdl/zip_stored_entry_extractor_top.sv =====
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor_top
// Extracts the data of the first stored entry from a byte stream of a ZIP
// archive.
// ----------------------------------------------------------------------------
// Usage
//   The request channel carries one archive byte per transaction, with
//   req_archive_last set on the final byte of the archive. The block walks
//   the local headers, skips names, extra fields and unusable entries, and
//   passes the bytes of the first stored entry to the response channel.
//   A data response has rsp_result_kind low; its last byte has
//   rsp_entry_last set. A status response (kind high) ends the archive with
//   an error code, and the consumer then discards any data it received.
//   One byte is taken every cycle while the queue has room. A byte's
//   responses appear in the queue in the cycle after it is accepted; a
//   byte may give none, one or two. The request side stays ready while
//   the response queue holds at most RSP_DEPTH-2 items, so a stalled
//   receiver stops input only once the queue holds more; nothing is
//   lost. Reset empties the queue and returns the parser to the start
//   of a header. A byte after the final archive byte starts a new archive.
// ----------------------------------------------------------------------------
module zip_stored_entry_extractor_top #(
   parameter int RSP_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_archive_byte,
   input  logic       req_archive_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_entry_last,
   output logic [2:0] rsp_status
);

   zsee_pkg::rsp_push_type push;
   zsee_pkg::rsp_item_type head;
   logic                   accept;

   assign accept = req_valid && req_ready;

   zsee_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .archive_byte (req_archive_byte),
      .archive_last (req_archive_last),
      .push         (push)
   );

   zsee_rsp_fifo #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head)
   );

   assign rsp_result_kind = head.result_kind;
   assign rsp_out_byte    = head.out_byte;
   assign rsp_entry_last  = head.entry_last;
   assign rsp_status      = head.status;

endmodule
